// ----- sv/rtu_pkg.sv -----
// shared types and constants of the receive fifo with silence timeout
`default_nettype none
package rtu_pkg;

    typedef enum logic [2:0] {
        OP_RX       = 3'd0,
        OP_TICK     = 3'd1,
        OP_READ     = 3'd2,
        OP_TX_BEGIN = 3'd3,
        OP_TX_END   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic restart;
        logic stop;
        logic tick;
    } t_tmr_ctl;

    typedef struct packed {
        logic expire;
    } t_tmr_sts;

    localparam logic [6:0]  MAX_POP       = 7'd64;
    localparam logic [15:0] SILENCE_RESET = 16'd4096;

endpackage
`default_nettype wire

// ----- sv/rtu_if.sv -----
// input and output stream interfaces of the receive fifo
`default_nettype none
interface rtu_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [7:0] rx_byte;
    logic [6:0] read_count;

    modport source (output valid, output operation, output rx_byte, output read_count,
                    input ready);
    modport sink (input valid, input operation, input rx_byte, input read_count,
                  output ready);
endinterface

interface rtu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       byte_valid;
    logic       last_of_run;
    logic       frame_done;
    logic [7:0] fill_level;
    logic       byte_dropped;

    modport source (output valid, output read_data, output byte_valid, output last_of_run,
                    output frame_done, output fill_level, output byte_dropped,
                    input ready);
    modport sink (input valid, input read_data, input byte_valid, input last_of_run,
                  input frame_done, input fill_level, input byte_dropped,
                  output ready);
endinterface
`default_nettype wire

// ----- sv/rtu_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none
module rtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- sv/rtu_timer.sv -----
// silence timer with its configuration register
`default_nettype none
module rtu_timer (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [15:0]      i_cfg_wdata,
    input  wire rtu_pkg::t_tmr_ctl i_ctl,
    output rtu_pkg::t_tmr_sts     o_sts
);

    logic [15:0] r_ticks, n_ticks;
    logic [15:0] r_count, n_count;
    logic        r_running, n_running;
    logic        low;

    // a count of zero or one both end on this tick
    assign low = (r_count <= 16'd1);
    assign o_sts.expire = i_ctl.tick && r_running && low;

    always_comb begin
        n_ticks   = i_cfg_we ? i_cfg_wdata : r_ticks;
        n_count   = r_count;
        n_running = r_running;
        if (i_ctl.restart) begin
            n_count   = r_ticks;
            n_running = 1'b1;
        end else if (i_ctl.stop) begin
            n_running = 1'b0;
        end else if (i_ctl.tick && r_running) begin
            if (low) begin
                n_count   = '0;
                n_running = 1'b0;
            end else begin
                n_count = r_count - 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks   <= rtu_pkg::SILENCE_RESET;
            r_count   <= '0;
            r_running <= 1'b0;
        end else begin
            r_ticks   <= n_ticks;
            r_count   <= n_count;
            r_running <= n_running;
        end
    end

endmodule
`default_nettype wire

// ----- sv/rtu_ctrl.sv -----
// sequencer, ring pointers and fill count, result register
`default_nettype none
module rtu_ctrl #(
    parameter int DEPTH = 256
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    rtu_in_if.sink                         i_in,
    rtu_out_if.source                      o_out,
    output rtu_pkg::t_tmr_ctl              o_tmr_ctl,
    input  wire rtu_pkg::t_tmr_sts         i_tmr_sts,
    output logic                           o_ram_we,
    output logic      [$clog2(DEPTH)-1:0]  o_ram_waddr,
    output logic      [7:0]                o_ram_wdata,
    output logic                           o_ram_re,
    output logic      [$clog2(DEPTH)-1:0]  o_ram_raddr,
    input  wire logic [7:0]                i_ram_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = (AW > 8) ? AW : 8;

    rtu_pkg::t_state r_state, n_state;

    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [AW-1:0] r_count, n_count;
    logic          r_frame, n_frame;
    logic          r_tx, n_tx;
    logic [6:0]    r_rem, n_rem;
    logic [7:0]    r_data, n_data;
    logic          r_valid, n_valid;
    logic          r_last, n_last;
    logic          r_drop, n_drop;

    logic          in_xfer;
    logic          out_xfer;
    logic          full;
    logic          pop_start;
    logic [6:0]    clamp;
    logic [FW-1:0] fill_ext;

    assign in_xfer   = i_in.valid && i_in.ready;
    assign out_xfer  = o_out.valid && o_out.ready;
    assign full      = (r_count == AW'(DEPTH - 1));
    assign clamp     = (i_in.read_count > rtu_pkg::MAX_POP) ? rtu_pkg::MAX_POP
                                                            : i_in.read_count;
    assign pop_start = (i_in.operation == rtu_pkg::OP_READ) && (clamp != 7'd0)
                       && (r_count != '0);

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rtu_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = pop_start ? rtu_pkg::ST_FETCH : rtu_pkg::ST_EMIT;
                end
            end
            rtu_pkg::ST_FETCH: begin
                n_state = rtu_pkg::ST_EMIT;
            end
            rtu_pkg::ST_EMIT: begin
                if (out_xfer) begin
                    n_state = r_last ? rtu_pkg::ST_IDLE : rtu_pkg::ST_FETCH;
                end
            end
            default: begin
                n_state = rtu_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        i_in.ready        = (r_state == rtu_pkg::ST_IDLE);
        o_out.valid       = (r_state == rtu_pkg::ST_EMIT);
        o_ram_re          = (in_xfer && pop_start) ||
                            ((r_state == rtu_pkg::ST_EMIT) && out_xfer && !r_last);
        o_ram_raddr       = r_rd_ptr;
        o_ram_we          = in_xfer && (i_in.operation == rtu_pkg::OP_RX) && !r_tx && !full;
        o_ram_waddr       = r_wr_ptr;
        o_ram_wdata       = i_in.rx_byte;
        o_tmr_ctl.restart = in_xfer && (i_in.operation == rtu_pkg::OP_RX) && !r_tx;
        o_tmr_ctl.stop    = in_xfer && (i_in.operation == rtu_pkg::OP_TX_BEGIN);
        o_tmr_ctl.tick    = in_xfer && (i_in.operation == rtu_pkg::OP_TICK);
    end

    // datapath next values
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        n_frame  = r_frame;
        n_tx     = r_tx;
        n_rem    = r_rem;
        n_data   = r_data;
        n_valid  = r_valid;
        n_last   = r_last;
        n_drop   = r_drop;
        if (in_xfer) begin
            n_data  = '0;
            n_valid = 1'b0;
            n_last  = 1'b1;
            n_drop  = 1'b0;
            case (i_in.operation)
                rtu_pkg::OP_RX: begin
                    if (!r_tx) begin
                        if (!full) begin
                            n_wr_ptr = advance(r_wr_ptr);
                            n_count  = r_count + 1'b1;
                        end else begin
                            n_drop = 1'b1;
                        end
                    end
                end
                rtu_pkg::OP_TICK: begin
                    if (i_tmr_sts.expire && (r_count != '0)) begin
                        n_frame = 1'b1;
                    end
                end
                rtu_pkg::OP_READ: begin
                    n_rem = clamp;
                end
                rtu_pkg::OP_TX_BEGIN: begin
                    n_tx = 1'b1;
                end
                rtu_pkg::OP_TX_END: begin
                    n_wr_ptr = '0;
                    n_rd_ptr = '0;
                    n_count  = '0;
                    n_frame  = 1'b0;
                    n_tx     = 1'b0;
                end
                default: begin
                end
            endcase
        end else if (r_state == rtu_pkg::ST_FETCH) begin
            // one byte popped per pass through fetch
            n_data   = i_ram_rdata;
            n_valid  = 1'b1;
            n_last   = (r_rem == 7'd1) || (r_count == AW'(1));
            n_drop   = 1'b0;
            n_rd_ptr = advance(r_rd_ptr);
            n_count  = r_count - 1'b1;
            n_rem    = r_rem - 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rtu_pkg::ST_IDLE;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_frame  <= 1'b0;
            r_tx     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            r_frame  <= n_frame;
            r_tx     <= n_tx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_data  <= n_data;
        r_valid <= n_valid;
        r_last  <= n_last;
        r_drop  <= n_drop;
    end

    // fill count is settled once the result is shown
    assign fill_ext = FW'(r_count);

    assign o_out.read_data    = r_data;
    assign o_out.byte_valid   = r_valid;
    assign o_out.last_of_run  = r_last;
    assign o_out.frame_done   = r_frame;
    assign o_out.fill_level   = (fill_ext > FW'(255)) ? 8'hFF : fill_ext[7:0];
    assign o_out.byte_dropped = r_drop;

endmodule
`default_nettype wire

// ----- sv/rtu_rx_fifo_frame_timeout_top.sv -----
// receive fifo top: one transfer in, its results out, then ready again
// non-read operations: one result, valid the cycle after the input transfer
// reads: each byte passes through fetch, where the registered read port of the ring ram
// delivers it, then emit until the receiver takes it, before the next one is fetched; up to 64 bytes per read
// reset (synchronous, active low) clears pointers, flags and timer, and sets
// silence_ticks to 4096; ring contents are not cleared
`default_nettype none
module rtu_rx_fifo_frame_timeout_top #(
    parameter int DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    rtu_in_if.sink           i_in,
    rtu_out_if.source        o_out
);

    localparam int AW = $clog2(DEPTH);

    rtu_pkg::t_tmr_ctl tmr_ctl;
    rtu_pkg::t_tmr_sts tmr_sts;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [7:0]        ram_rdata;

    rtu_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_tmr_ctl   (tmr_ctl),
        .i_tmr_sts   (tmr_sts),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    rtu_timer u_timer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ctl       (tmr_ctl),
        .o_sts       (tmr_sts)
    );

    rtu_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule
`default_nettype wire

// ----- sv/rtu_chk.sv -----
// port-level checker of the receive fifo, bound to the top level
`default_nettype none
module rtu_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic [2:0] i_in_operation,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_read_data,
    input wire logic       i_out_byte_valid,
    input wire logic       i_out_last_of_run,
    input wire logic       i_out_frame_done,
    input wire logic [7:0] i_out_fill_level
);

    logic in_xfer;
    assign in_xfer = i_in_valid && i_in_ready;

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_read_data)
            && $stable(i_out_byte_valid) && $stable(i_out_last_of_run))
        else $error("stalled result changed");

    // one item at a time: no input transfer while a result is shown
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while result pending");

    // every non-read transfer gives one status result in the next cycle
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_in_operation != rtu_pkg::OP_READ) |=>
            i_out_valid && i_out_last_of_run && !i_out_byte_valid)
        else $error("missing status result");

    // no byte means zero data
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_byte_valid |-> (i_out_read_data == 8'd0))
        else $error("data without a byte");

    // end of transmit flushes the ring and clears the frame flag
    a_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_in_operation == rtu_pkg::OP_TX_END) |=>
            !i_out_frame_done && (i_out_fill_level == 8'd0))
        else $error("transmit end did not flush");

endmodule

bind rtu_rx_fifo_frame_timeout_top rtu_chk u_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_in_operation    (i_in.operation),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_read_data   (o_out.read_data),
    .i_out_byte_valid  (o_out.byte_valid),
    .i_out_last_of_run (o_out.last_of_run),
    .i_out_frame_done  (o_out.frame_done),
    .i_out_fill_level  (o_out.fill_level)
);
`default_nettype wire

// ----- tb/rtu_rx_result_check.sv -----
`timescale 1ns / 100ps
// result checker for the receive fifo: predicts results from input transfers and compares
module rtu_rx_result_check #(
    parameter int DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    rtu_in_if           i_in_mon,
    rtu_out_if          i_out_mon,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_pops,
    output int          o_drops
);

    typedef struct packed {
        logic [7:0] read_data;
        logic       byte_valid;
        logic       last_of_run;
        logic       frame_done;
        logic [7:0] fill_level;
        logic       byte_dropped;
    } t_rx_result;

    logic [7:0]  ring_mem [DEPTH];
    int          wr_ptr;
    int          rd_ptr;
    logic        frame_flag;
    logic        in_tx;
    logic        timer_on;
    logic [15:0] ticks_left;
    logic [15:0] silence_ticks;
    t_rx_result  pending_results [$];
    int          err_cnt = 0;
    int          result_cnt = 0;
    int          pop_cnt = 0;
    int          drop_cnt = 0;

    function automatic int next_slot(int p);
        return (p + 1 >= DEPTH) ? 0 : p + 1;
    endfunction

    function automatic int ring_held();
        return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + DEPTH - rd_ptr;
    endfunction

    task automatic queue_result(logic [7:0] data, logic vld, logic last, logic dropped);
        t_rx_result r;
        int         held;
        held = ring_held();
        r.read_data    = data;
        r.byte_valid   = vld;
        r.last_of_run  = last;
        r.frame_done   = frame_flag;
        r.fill_level   = (held > 255) ? 8'd255 : 8'(held);
        r.byte_dropped = dropped;
        pending_results.push_back(r);
    endtask

    task automatic apply_item(logic [2:0] op, logic [7:0] data, logic [6:0] count);
        int         limit;
        int         popped;
        logic       dropped;
        logic [7:0] head;
        dropped = 1'b0;
        popped  = 0;
        case (op)
            rtu_pkg::OP_RX: begin
                // bytes that arrive while transmitting are ignored entirely
                if (!in_tx) begin
                    if (next_slot(wr_ptr) != rd_ptr) begin
                        ring_mem[wr_ptr] = data;
                        wr_ptr = next_slot(wr_ptr);
                    end else begin
                        dropped = 1'b1;
                        drop_cnt++;
                    end
                    ticks_left = silence_ticks;
                    timer_on   = 1'b1;
                end
            end
            rtu_pkg::OP_TICK: begin
                if (timer_on) begin
                    // a silence setting of zero expires like one
                    if (ticks_left <= 16'd1) begin
                        ticks_left = 16'd0;
                        timer_on   = 1'b0;
                        if (wr_ptr != rd_ptr) frame_flag = 1'b1;
                    end else begin
                        ticks_left = ticks_left - 16'd1;
                    end
                end
            end
            rtu_pkg::OP_READ: begin
                limit = (count > rtu_pkg::MAX_POP) ? int'(rtu_pkg::MAX_POP) : int'(count);
                while (popped < limit && rd_ptr != wr_ptr) begin
                    head   = ring_mem[rd_ptr];
                    rd_ptr = next_slot(rd_ptr);
                    queue_result(head, 1'b1, (popped + 1 == limit) || (rd_ptr == wr_ptr), 1'b0);
                    popped++;
                end
            end
            rtu_pkg::OP_TX_BEGIN: begin
                in_tx    = 1'b1;
                timer_on = 1'b0;
            end
            rtu_pkg::OP_TX_END: begin
                wr_ptr     = 0;
                rd_ptr     = 0;
                frame_flag = 1'b0;
                in_tx      = 1'b0;
            end
            default: ;
        endcase
        if (popped == 0) queue_result(8'h00, 1'b0, 1'b1, dropped);
    endtask

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        err_cnt++;
        if (err_cnt <= 40)
            $display("[%0t] result %0d: %s got %h want %h", $time, result_cnt, what, got, want);
    endtask

    task automatic check_result();
        t_rx_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with none pending, read_data", i_out_mon.read_data, 8'h00);
        end else begin
            want = pending_results.pop_front();
            if (want.byte_valid) pop_cnt++;
            if (i_out_mon.read_data !== want.read_data)
                report_mismatch("read_data", i_out_mon.read_data, want.read_data);
            if (i_out_mon.byte_valid !== want.byte_valid)
                report_mismatch("byte_valid", 8'(i_out_mon.byte_valid), 8'(want.byte_valid));
            if (i_out_mon.last_of_run !== want.last_of_run)
                report_mismatch("last_of_run", 8'(i_out_mon.last_of_run),
                                8'(want.last_of_run));
            if (i_out_mon.frame_done !== want.frame_done)
                report_mismatch("frame_done", 8'(i_out_mon.frame_done), 8'(want.frame_done));
            if (i_out_mon.fill_level !== want.fill_level)
                report_mismatch("fill_level", i_out_mon.fill_level, want.fill_level);
            if (i_out_mon.byte_dropped !== want.byte_dropped)
                report_mismatch("byte_dropped", 8'(i_out_mon.byte_dropped),
                                8'(want.byte_dropped));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wr_ptr        = 0;
            rd_ptr        = 0;
            frame_flag    = 1'b0;
            in_tx         = 1'b0;
            timer_on      = 1'b0;
            ticks_left    = 16'd0;
            silence_ticks = rtu_pkg::SILENCE_RESET;
            pending_results.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                result_cnt++;
                check_result();
            end
            if (i_cfg_we) silence_ticks = i_cfg_wdata;
            if (i_in_mon.valid && i_in_mon.ready)
                apply_item(i_in_mon.operation, i_in_mon.rx_byte, i_in_mon.read_count);
        end
        o_errors  <= err_cnt;
        o_pending <= pending_results.size();
        o_results <= result_cnt;
        o_pops    <= pop_cnt;
        o_drops   <= drop_cnt;
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// testbench top for the receive fifo: stimulus, receiver stalls, verdict
module tb_top;

    localparam int         DEPTH        = 256;
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_MD = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    rtu_in_if  in_ch ();
    rtu_out_if out_ch ();

    int          err_cnt;
    int          pending_cnt;
    int          result_cnt;
    int          pop_cnt;
    int          drop_cnt;
    int          burst_left = 0;
    int          items_sent = 0;
    int          settings_used = 1;
    logic [15:0] silence_cur = rtu_pkg::SILENCE_RESET;

    rtu_rx_fifo_frame_timeout_top #(
        .DEPTH (DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    rtu_rx_result_check #(
        .DEPTH (DEPTH)
    ) u_result_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_mon    (in_ch),
        .i_out_mon   (out_ch),
        .o_errors    (err_cnt),
        .o_pending   (pending_cnt),
        .o_results   (result_cnt),
        .o_pops      (pop_cnt),
        .o_drops     (drop_cnt)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // one transfer per call; valid stays high between calls inside a burst
    task automatic send_item(logic [2:0] op, logic [7:0] data, logic [6:0] count);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (items_sent % 96 < 24 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid      <= 1'b1;
        in_ch.operation  <= op;
        in_ch.rx_byte    <= data;
        in_ch.read_count <= count;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic send_rx(logic [7:0] data);
        send_item(rtu_pkg::OP_RX, data, 7'($urandom));
    endtask

    task automatic send_read(logic [6:0] count);
        send_item(rtu_pkg::OP_READ, 8'($urandom), count);
    endtask

    task automatic send_op(logic [2:0] op);
        send_item(op, 8'($urandom), 7'($urandom));
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_op(rtu_pkg::OP_TICK);
    endtask

    // drop valid and wait until every pending result has come back
    task automatic settle();
        in_ch.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_silence(logic [15:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        silence_cur = value;
        settings_used++;
    endtask

    // receiver: changing stall patterns plus a long hold-off now and then
    initial begin : receiver
        int rx_cycle;
        int hold_left;
        int stall_mode;
        rx_cycle   = 0;
        hold_left  = 0;
        stall_mode = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (rx_cycle % 1200 == 700) hold_left = $urandom_range(100, 150);
            if (rx_cycle % 80 == 0) stall_mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ch.ready <= $urandom_range(0, 1);
                    default: out_ch.ready <= (rx_cycle % 3 != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [15:0] phase_silence [5];
        int          i;
        int          nbytes;
        int          eff;
        int          kind;
        int          phase_start;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= 16'h0000;
        in_ch.valid      <= 1'b0;
        in_ch.operation  <= rtu_pkg::OP_RX;
        in_ch.rx_byte    <= 8'h00;
        in_ch.read_count <= 7'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty reads, idle tick, spare codes, clamp, transmit corner cases
        send_read(7'd1);
        send_read(7'd0);
        send_op(rtu_pkg::OP_TICK);
        send_op(OP_UNUSED_LO);
        send_op(OP_UNUSED_MD);
        send_op(OP_UNUSED_HI);
        send_rx(8'h00);
        send_rx(8'hFF);
        send_rx(8'hA5);
        send_op(rtu_pkg::OP_TICK);
        send_read(7'd0);
        send_read(7'd127);
        send_rx(8'h5A);
        send_op(rtu_pkg::OP_TX_BEGIN);
        send_rx(8'h33);
        send_read(7'd1);
        send_op(rtu_pkg::OP_TX_END);
        send_op(rtu_pkg::OP_TX_END);
        write_silence(16'd1);
        // timer runs out on an empty ring, then on a filled one
        send_rx(8'h11);
        send_read(7'd64);
        send_op(rtu_pkg::OP_TICK);
        send_rx(8'h22);
        send_op(rtu_pkg::OP_TICK);
        send_read(7'd64);
        send_op(rtu_pkg::OP_TX_END);

        phase_silence = '{16'hFFFF, 16'h0000, 16'd3, 16'd1, 16'd0};
        phase_silence[4] = 16'($urandom_range(2, 12));
        for (i = 0; i < 5; i++) begin
            write_silence(phase_silence[i]);
            eff = (silence_cur == 16'd0) ? 1 : int'(silence_cur);
            phase_start = items_sent;
            if (silence_cur == 16'd3) begin
                // overfill the ring so the last three bytes get dropped, then drain it
                send_op(rtu_pkg::OP_TX_END);
                repeat (DEPTH + 2) send_rx(8'($urandom));
                send_ticks(eff + 1);
                repeat (4) send_read(7'd64);
                send_read(7'd127);
            end
            while (items_sent - phase_start < 16) begin
                kind = $urandom_range(0, 9);
                if (kind < 6) begin
                    // well-formed frame: bytes, silence until timeout, reads, turnaround
                    if ($urandom_range(0, 3) == 0) begin
                        send_op(rtu_pkg::OP_TX_BEGIN);
                        if ($urandom_range(0, 1) == 1) send_rx(8'($urandom));
                        send_op(rtu_pkg::OP_TX_END);
                    end
                    nbytes = $urandom_range(1, 12);
                    repeat (nbytes) begin
                        send_rx(8'($urandom));
                        if ($urandom_range(0, 5) == 0) send_op(rtu_pkg::OP_TICK);
                    end
                    if (eff <= 16) send_ticks(eff + $urandom_range(0, 1));
                    else send_ticks($urandom_range(1, 3));
                    if ($urandom_range(0, 3) == 0) send_read(7'(nbytes));
                    else send_read(7'($urandom_range(1, 64)));
                    if ($urandom_range(0, 1) == 1) send_read(7'($urandom_range(0, 127)));
                    if ($urandom_range(0, 1) == 1) begin
                        send_op(rtu_pkg::OP_TX_BEGIN);
                        send_op(rtu_pkg::OP_TX_END);
                    end
                end else if (kind < 8) begin
                    repeat ($urandom_range(1, 6))
                        send_item(3'($urandom_range(0, 7)), 8'($urandom), 7'($urandom));
                end else begin
                    // broken frames: transmit mid-frame, early read, flush without timeout
                    repeat ($urandom_range(1, 4)) send_rx(8'($urandom));
                    case ($urandom_range(0, 2))
                        0: begin
                            send_op(rtu_pkg::OP_TX_BEGIN);
                            repeat ($urandom_range(1, 3)) send_rx(8'($urandom));
                            send_read(7'($urandom_range(0, 127)));
                            send_op(rtu_pkg::OP_TX_END);
                        end
                        1: begin
                            send_read(7'($urandom_range(1, 64)));
                            send_rx(8'($urandom));
                            send_ticks($urandom_range(1, 3));
                        end
                        default: begin
                            send_op(rtu_pkg::OP_TX_END);
                            send_ticks($urandom_range(1, 2));
                        end
                    endcase
                end
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        $display("summary: %0d input items under %0d silence settings, %0d results compared",
                 items_sent, settings_used, result_cnt);
        $display("summary: %0d bytes popped, %0d bytes dropped on a full ring, %0d mismatches",
                 pop_cnt, drop_cnt, err_cnt);
        if (err_cnt == 0 && pending_cnt == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
